// File: rtl/afd_pkg.sv
`timescale 1ns / 1ps

package afd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_SAMPLES    = 2'd2;

    localparam logic        RESET_GLITCH_ENABLE    = 1'b1;
    localparam logic [15:0] RESET_GLITCH_THRESHOLD = 16'd500;
    localparam logic [15:0] RESET_FRAME_SAMPLES    = 16'd1000;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int M_DATA_W    = 88;

    typedef struct packed {
        logic        glitch_enable;
        logic [15:0] glitch_threshold;
        logic [15:0] frame_samples;
    } afd_cfg_t;

endpackage

// File: rtl/afd_front.sv
`timescale 1ns / 1ps

module afd_front
    import afd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 4,
    parameter int CW            = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  afd_cfg_t      cfg,
    input  logic          byte_valid,
    input  logic [7:0]    byte_data,
    output logic          push_valid,
    output logic          push_reject,
    output logic [CW-1:0] push_chan,
    output logic [15:0]   push_raw
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PRE      = 3'd1;
    localparam logic [2:0] PH_CHAN     = 3'd2;
    localparam logic [2:0] PH_PAD      = 3'd3;
    localparam logic [2:0] PH_PAD_DROP = 3'd4;
    localparam logic [2:0] PH_DATA     = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] chan_reg, chan_next;
    logic          held_reg, held_next;
    logic [7:0]    held_byte_reg, held_byte_next;
    logic [15:0]   count_reg, count_next;
    logic [15:0]   prev_reg, prev_next;

    logic [15:0] raw;
    logic [15:0] count_inc;
    logic        frame_end;
    logic [16:0] diff;
    logic [16:0] abs_diff;
    logic        reject;
    logic [2:0]  scan_phase;

    assign raw       = {byte_data, held_byte_reg};
    assign count_inc = count_reg + 16'd1;
    assign frame_end = count_inc >= cfg.frame_samples;
    assign diff      = {raw[15], raw} - {prev_reg[15], prev_reg};
    assign abs_diff  = diff[16] ? (17'd0 - diff) : diff;
    assign reject    = cfg.glitch_enable && (prev_reg != 16'd0)
                       && (abs_diff > {1'b0, cfg.glitch_threshold});
    assign scan_phase = (byte_data == SYNC_BYTE) ? PH_PRE : PH_IDLE;

    assign push_valid  = byte_valid && (phase_reg == PH_DATA) && held_reg;
    assign push_reject = reject;
    assign push_chan   = chan_reg;
    assign push_raw    = raw;

    always_comb begin
        phase_next     = phase_reg;
        chan_next      = chan_reg;
        held_next      = held_reg;
        held_byte_next = held_byte_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        if (byte_valid) begin
            unique case (phase_reg)
                PH_PRE: begin
                    phase_next = (byte_data == SYNC_BYTE) ? PH_CHAN : PH_IDLE;
                end
                PH_CHAN: begin
                    if (byte_data >= 8'd1 && byte_data <= 8'(CHANNEL_COUNT)) begin
                        chan_next  = CW'(byte_data - 8'd1);
                        phase_next = PH_PAD;
                    end else begin
                        phase_next = PH_PAD_DROP;
                    end
                end
                PH_PAD: begin
                    phase_next = PH_DATA;
                    held_next  = 1'b0;
                end
                PH_PAD_DROP: begin
                    phase_next = PH_IDLE;
                end
                PH_DATA: begin
                    if (!held_reg) begin
                        held_next      = 1'b1;
                        held_byte_next = byte_data;
                    end else if (reject) begin
                        if (frame_end) begin
                            held_next  = 1'b0;
                            count_next = 16'd0;
                            phase_next = scan_phase;
                        end else begin
                            held_next      = 1'b1;
                            held_byte_next = byte_data;
                            count_next     = count_inc;
                        end
                    end else begin
                        held_next = 1'b0;
                        prev_next = raw;
                        if (frame_end) begin
                            count_next = 16'd0;
                            phase_next = PH_IDLE;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
                default: begin
                    phase_next = scan_phase;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            chan_reg      <= '0;
            held_reg      <= 1'b0;
            held_byte_reg <= 8'd0;
            count_reg     <= 16'd0;
            prev_reg      <= 16'd0;
        end else begin
            phase_reg     <= phase_next;
            chan_reg      <= chan_next;
            held_reg      <= held_next;
            held_byte_reg <= held_byte_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
        end
    end

endmodule

// File: rtl/afd_fifo.sv
`timescale 1ns / 1ps

module afd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign empty     = (count_reg == NW'(0));
    assign full      = (count_reg == NW'(DEPTH));
    assign head_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/afd_back.sv
`timescale 1ns / 1ps

module afd_back
    import afd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 4,
    parameter int CW            = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  logic                head_reject,
    input  logic [CW-1:0]       head_chan,
    input  logic [15:0]         head_raw,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    logic [31:0] acc_reg [CHANNEL_COUNT];
    logic [31:0] run_reg [CHANNEL_COUNT];
    logic        split_reg, split_next;
    logic        valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic        kind_reg, kind_next;
    logic        last_reg, last_next;

    logic        load;
    logic [31:0] acc;
    logic [31:0] run;
    logic [31:0] run_inc;
    logic [2:0]  chan_number;
    logic        emit_reject;
    logic        emit_split;
    logic        emit_sample;

    assign load        = !valid_reg || m_tready;
    assign acc         = acc_reg[head_chan];
    assign run         = run_reg[head_chan];
    assign run_inc     = run + 32'd1;
    assign chan_number = 3'(head_chan) + 3'd1;

    assign emit_reject = head_valid && load && head_reject;
    assign emit_split  = head_valid && load && !head_reject
                         && (run != 32'd0) && !split_reg;
    assign emit_sample = head_valid && load && !head_reject && !emit_split;
    assign pop         = emit_reject || emit_sample;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        split_next = split_reg;
        if (load) begin
            valid_next = head_valid;
        end
        if (emit_reject) begin
            kind_next = KIND_RUN;
            last_next = 1'b1;
            data_next = {5'd0, run_inc, acc, 16'd0, chan_number};
        end else if (emit_split) begin
            kind_next  = KIND_RUN;
            last_next  = 1'b0;
            data_next  = {5'd0, run, acc, 16'd0, chan_number};
            split_next = 1'b1;
        end else if (emit_sample) begin
            kind_next  = KIND_SAMPLE;
            last_next  = 1'b1;
            data_next  = {5'd0, 32'd0, acc, head_raw, chan_number};
            split_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            split_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                acc_reg[i] <= 32'd0;
                run_reg[i] <= 32'd0;
            end
        end else begin
            valid_reg <= valid_next;
            split_reg <= split_next;
            if (emit_reject) begin
                run_reg[head_chan] <= run_inc;
            end else if (emit_sample) begin
                run_reg[head_chan] <= 32'd0;
                acc_reg[head_chan] <= acc + 32'd1;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/adc_frame_deframer_glitch_reject.sv
`timescale 1ns / 1ps
// Channel  | Dir | Beat contents
// s_       | in  | tdata[7:0] data_byte
// m_       | out | tdata: channel_number, sample_value, output_position,
//          |     |   error_run_length; tuser record_kind; tlast last_of_run
// cfg_     | in  | cfg_addr selects glitch_enable, glitch_threshold, frame_samples
//
// One byte is taken per cycle while the four-entry sample queue has room.
// The record stage sends one beat per cycle; a good sample that closes an error
// run needs two beats, and the queue absorbs that extra beat, so bytes keep
// flowing at one per cycle while m_tready stays high.
// A record passes through the sample queue before it reaches the output register;
// a closing run record is sent ahead of the sample that it closes.
// Synchronous reset clears the parser, the channel counters, the queue and the output valid,
// and sets the config registers to their defaults; a stalled m_ side backs up through the queue.

module adc_frame_deframer_glitch_reject
    import afd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] channel_number, [18:3] sample_value, [50:19] output_position,
    // [82:51] error_run_length, [87:83] zero
    output logic [M_DATA_W-1:0]    m_tdata,
    output logic                   m_tuser,   // [0] record_kind
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int QW = 1 + CW + 16;

    afd_cfg_t cfg_reg;

    logic          byte_valid;
    logic          push_valid;
    logic          push_reject;
    logic [CW-1:0] push_chan;
    logic [15:0]   push_raw;
    logic [QW-1:0] head_data;
    logic          q_empty;
    logic          q_full;
    logic          pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.glitch_enable    <= RESET_GLITCH_ENABLE;
            cfg_reg.glitch_threshold <= RESET_GLITCH_THRESHOLD;
            cfg_reg.frame_samples    <= RESET_FRAME_SAMPLES;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GLITCH_ENABLE:    cfg_reg.glitch_enable    <= cfg_wdata[0];
                REG_GLITCH_THRESHOLD: cfg_reg.glitch_threshold <= cfg_wdata;
                REG_FRAME_SAMPLES:    cfg_reg.frame_samples    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    afd_front #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .CW           (CW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_data  (s_tdata),
        .push_valid (push_valid),
        .push_reject(push_reject),
        .push_chan  (push_chan),
        .push_raw   (push_raw)
    );

    afd_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_data({push_reject, push_chan, push_raw}),
        .pop      (pop),
        .head_data(head_data),
        .empty    (q_empty),
        .full     (q_full)
    );

    afd_back #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .CW           (CW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head_reject(head_data[QW-1]),
        .head_chan  (head_data[QW-2:16]),
        .head_raw   (head_data[15:0]),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("sample queue written while full");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("sample queue read while empty");

    a_sample_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SAMPLE)) |-> m_tlast)
        else $error("sample record not marked last");

    a_split_then_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser == KIND_SAMPLE)))
        else $error("closing run record not followed by its sample");

endmodule

// File: tb/tb_adc_frame_deframer_glitch_reject.sv
`timescale 1ns / 1ps

module tb_adc_frame_deframer_glitch_reject;
    import afd_pkg::*;

    localparam int CHANNELS      = 4;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_BYTES = 115;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 40;
    localparam int PREDICTED     = -1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SYNC2,
        SCAN_CHANNEL,
        SCAN_PAD,
        SCAN_PAD_SKIP,
        SCAN_SAMPLES
    } scan_phase_e;

    typedef enum logic {ROW_BYTE, ROW_WRITE} row_op_e;

    typedef struct packed {
        logic        kind;
        logic [2:0]  chan;
        logic [15:0] sample;
        logic [31:0] pos;
        logic [31:0] run;
        logic        last;
    } adc_record_t;

    typedef struct {
        row_op_e                op;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [15:0]            value;
        int                     n_typed;
        adc_record_t            rec_a;
        adc_record_t            rec_b;
    } script_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic        cfg_enable;
    logic [15:0] cfg_threshold;
    logic [15:0] cfg_frame_len;
    scan_phase_e scan_phase;
    logic [1:0]  chan_idx;
    logic        low_held;
    logic [7:0]  low_byte;
    logic [15:0] reads_in_frame;
    logic [15:0] last_good;
    logic [31:0] good_count [CHANNELS];
    logic [31:0] reject_count [CHANNELS];

    adc_record_t expected_records [$];

    int errors       = 0;
    int bytes_sent   = 0;
    int reg_writes   = 0;
    int sample_beats = 0;
    int run_beats    = 0;
    int idle_cycles  = 0;
    int tx_idle_pct  = 22;
    int rx_idle_pct  = 87;

    adc_frame_deframer_glitch_reject #(
        .CHANNEL_COUNT(CHANNELS)
    ) dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic adc_record_t beat_of(logic kind, logic [2:0] chan, logic [15:0] sample,
                                            logic [31:0] pos, logic [31:0] run, logic last);
        beat_of = '{kind, chan, sample, pos, run, last};
    endfunction

    function automatic script_row_t byte_row(logic [7:0] b);
        byte_row = '{ROW_BYTE, '0, 16'(b), PREDICTED, '0, '0};
    endfunction

    function automatic script_row_t typed_row(logic [7:0] b, int n, adc_record_t a,
                                              adc_record_t c);
        typed_row = '{ROW_BYTE, '0, 16'(b), n, a, c};
    endfunction

    function automatic script_row_t write_row(logic [CFG_INDEX_W-1:0] idx, logic [15:0] v);
        write_row = '{ROW_WRITE, idx, v, PREDICTED, '0, '0};
    endfunction

    function automatic void reset_predictor();
        cfg_enable     = RESET_GLITCH_ENABLE;
        cfg_threshold  = RESET_GLITCH_THRESHOLD;
        cfg_frame_len  = RESET_FRAME_SAMPLES;
        scan_phase     = SCAN_IDLE;
        chan_idx       = '0;
        low_held       = 1'b0;
        low_byte       = '0;
        reads_in_frame = '0;
        last_good      = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            good_count[i]   = '0;
            reject_count[i] = '0;
        end
    endfunction

    function automatic void queue_record(logic kind, logic [15:0] sample, logic [31:0] run);
        expected_records.push_back(beat_of(kind, 3'(chan_idx) + 3'd1, sample,
                                           good_count[chan_idx], run, 1'b0));
    endfunction

    function automatic int deframe_byte(logic [7:0] b);
        int          n0;
        int          jump;
        logic [15:0] raw;
        logic        ends;
        adc_record_t tail;
        n0 = expected_records.size();
        case (scan_phase)
            SCAN_SYNC2: scan_phase = (b == SYNC_BYTE) ? SCAN_CHANNEL : SCAN_IDLE;
            SCAN_CHANNEL: begin
                if (b >= 8'd1 && b <= 8'(CHANNELS)) begin
                    chan_idx   = 2'(b - 8'd1);
                    scan_phase = SCAN_PAD;
                end else begin
                    scan_phase = SCAN_PAD_SKIP;
                end
            end
            SCAN_PAD: begin
                scan_phase = SCAN_SAMPLES;
                low_held   = 1'b0;
            end
            SCAN_PAD_SKIP: scan_phase = SCAN_IDLE;
            SCAN_SAMPLES: begin
                if (!low_held) begin
                    low_held = 1'b1;
                    low_byte = b;
                end else begin
                    raw            = {b, low_byte};
                    low_held       = 1'b0;
                    reads_in_frame = reads_in_frame + 16'd1;
                    ends           = reads_in_frame >= cfg_frame_len;
                    jump           = int'($signed(raw)) - int'($signed(last_good));
                    if (jump < 0) begin
                        jump = -jump;
                    end
                    if (cfg_enable && last_good != '0 && jump > int'(cfg_threshold)) begin
                        reject_count[chan_idx] += 32'd1;
                        queue_record(KIND_RUN, '0, reject_count[chan_idx]);
                        if (ends) begin
                            // The slipped high byte is looked at again as a possible sync.
                            reads_in_frame = '0;
                            scan_phase     = (b == SYNC_BYTE) ? SCAN_SYNC2 : SCAN_IDLE;
                        end else begin
                            low_held = 1'b1;
                            low_byte = b;
                        end
                    end else begin
                        if (reject_count[chan_idx] != '0) begin
                            queue_record(KIND_RUN, '0, reject_count[chan_idx]);
                            reject_count[chan_idx] = '0;
                        end
                        last_good = raw;
                        queue_record(KIND_SAMPLE, raw, '0);
                        good_count[chan_idx] += 32'd1;
                        if (ends) begin
                            reads_in_frame = '0;
                            scan_phase     = SCAN_IDLE;
                        end
                    end
                end
            end
            default: scan_phase = (b == SYNC_BYTE) ? SCAN_SYNC2 : SCAN_IDLE;
        endcase
        if (expected_records.size() > n0) begin
            tail      = expected_records.pop_back();
            tail.last = 1'b1;
            expected_records.push_back(tail);
        end
        return expected_records.size() - n0;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        adc_record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser == KIND_SAMPLE) begin
                sample_beats++;
            end else begin
                run_beats++;
            end
            if (expected_records.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: unexpected beat, expected none, actual kind %0d channel %0d",
                             $time, m_tuser, m_tdata[2:0]);
                end
                errors++;
            end else begin
                want = expected_records.pop_front();
                check_field("record_kind", 32'(want.kind), 32'(m_tuser));
                check_field("channel_number", 32'(want.chan), 32'(m_tdata[2:0]));
                check_field("sample_value", 32'(want.sample), 32'(m_tdata[18:3]));
                check_field("output_position", want.pos, m_tdata[50:19]);
                check_field("error_run_length", want.run, m_tdata[82:51]);
                check_field("last_of_run", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic stream_byte(input logic [7:0] b);
        push_byte(b);
        void'(deframe_byte(b));
        bytes_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_GLITCH_ENABLE:    cfg_enable    = value[0];
            REG_GLITCH_THRESHOLD: cfg_threshold = value;
            REG_FRAME_SAMPLES:    cfg_frame_len = value;
            default: ;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic stream_frame();
        int          pick;
        int          span;
        logic [15:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) stream_byte(8'($urandom));
            return;
        end
        stream_byte(SYNC_BYTE);
        if (pick < 13) begin
            stream_byte(8'($urandom_range(0, 254)));
            return;
        end
        stream_byte(SYNC_BYTE);
        if (pick < 20) begin
            stream_byte(8'($urandom));
        end else begin
            stream_byte(8'($urandom_range(1, CHANNELS)));
        end
        stream_byte(8'($urandom));
        span = (cfg_threshold > 16'd4000) ? 4000 : int'(cfg_threshold) + 8;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0: s = 16'($urandom);
                1: s = '0;
                2: s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: s = last_good + 16'($urandom_range(0, 2 * span) - span);
            endcase
            stream_byte(s[7:0]);
            stream_byte(s[15:8]);
        end
    endtask

    initial begin
        script_row_t script [$];
        int          n;
        int          mark;
        logic        seg_en;
        logic [15:0] seg_thr;
        logic [15:0] seg_len;
        reset_predictor();
        // Rows with typed beats are read straight off the frame layout at the settings in force for each row.
        script = '{
            byte_row(SYNC_BYTE), byte_row(SYNC_BYTE), byte_row(8'h01), byte_row(8'h00),
            byte_row(8'h00),
            typed_row(8'h80, 1, beat_of(KIND_SAMPLE, 3'd1, 16'h8000, 32'd0, 32'd0, 1'b1), '0),
            byte_row(SYNC_BYTE),
            typed_row(8'h7F, 1, beat_of(KIND_RUN, 3'd1, 16'h0000, 32'd1, 32'd1, 1'b1), '0),
            typed_row(8'h80, 2, beat_of(KIND_RUN, 3'd1, 16'h0000, 32'd1, 32'd1, 1'b0),
                      beat_of(KIND_SAMPLE, 3'd1, 16'h807F, 32'd1, 32'd0, 1'b1)),
            write_row(REG_FRAME_SAMPLES, 16'd2),
            byte_row(8'h00),
            typed_row(8'h00, 1, beat_of(KIND_RUN, 3'd1, 16'h0000, 32'd2, 32'd1, 1'b1), '0),
            byte_row(SYNC_BYTE), byte_row(8'h12),
            byte_row(SYNC_BYTE), byte_row(SYNC_BYTE), byte_row(8'h07), byte_row(SYNC_BYTE),
            write_row(REG_FRAME_SAMPLES, 16'd0),
            write_row(REG_GLITCH_THRESHOLD, 16'd0),
            write_row(REG_UNMAPPED, 16'hFFFF),
            byte_row(SYNC_BYTE), byte_row(SYNC_BYTE), byte_row(8'h04), byte_row(8'h00),
            byte_row(SYNC_BYTE),
            typed_row(SYNC_BYTE, 1, beat_of(KIND_RUN, 3'd4, 16'h0000, 32'd0, 32'd1, 1'b1), '0),
            byte_row(SYNC_BYTE), byte_row(8'h00)
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].op == ROW_WRITE) begin
                settle();
                write_reg(script[i].reg_index, script[i].value);
            end else begin
                push_byte(script[i].value[7:0]);
                n = deframe_byte(script[i].value[7:0]);
                bytes_sent++;
                if (script[i].n_typed != PREDICTED) begin
                    repeat (n) void'(expected_records.pop_back());
                    if (script[i].n_typed > 0) begin
                        expected_records.push_back(script[i].rec_a);
                    end
                    if (script[i].n_typed > 1) begin
                        expected_records.push_back(script[i].rec_b);
                    end
                end
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                tx_idle_pct = 87;
                rx_idle_pct = 22;
            end
            if (seg == 2 * SEGMENTS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0: begin
                    seg_en  = 1'b1;
                    seg_thr = 16'd500;
                    seg_len = 16'd4;
                end
                1: begin
                    seg_en  = 1'b1;
                    seg_thr = 16'd0;
                    seg_len = 16'd1;
                end
                2: begin
                    seg_en  = 1'b0;
                    seg_thr = 16'hFFFF;
                    seg_len = 16'd3;
                end
                3: begin
                    seg_en  = 1'b1;
                    seg_thr = 16'hFFFF;
                    seg_len = 16'hFFFF;
                end
                4: begin
                    seg_en  = 1'b1;
                    seg_thr = 16'd100;
                    seg_len = 16'd2;
                end
                5: begin
                    seg_en  = 1'b1;
                    seg_thr = 16'd1;
                    seg_len = 16'd5;
                end
                default: begin
                    seg_en  = ($urandom_range(0, 3) != 0);
                    seg_thr = 16'($urandom_range(0, 2000));
                    seg_len = 16'($urandom_range(1, 8));
                end
            endcase
            settle();
            write_reg(REG_GLITCH_ENABLE, {15'($urandom), seg_en});
            write_reg(REG_GLITCH_THRESHOLD, seg_thr);
            write_reg(REG_FRAME_SAMPLES, seg_len);
            mark = bytes_sent;
            while (bytes_sent - mark < SEGMENT_BYTES) begin
                stream_frame();
            end
        end

        settle();
        $display("Streamed %0d bytes, %0d register writes; checked %0d sample and %0d run beats.",
                 bytes_sent, reg_writes, sample_beats, run_beats);
        $display("Backpressure came from each side in turn, then from neither.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/afd_pkg.sv
rtl/afd_front.sv
rtl/afd_fifo.sv
rtl/afd_back.sv
rtl/adc_frame_deframer_glitch_reject.sv
tb/tb_adc_frame_deframer_glitch_reject.sv
